>>> sv/moa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// moa_pkg: shared types and constants of the oversampling averager
// Field widths, default parameters and the records passed between stages.
// ----------------------------------------------------------------------------
package moa_pkg;

  localparam int unsigned SampleWidth  = 12;
  localparam int unsigned ChannelWidth = 4;
  localparam int unsigned FrameWidth   = 6;
  localparam int unsigned SumWidth     = 18;
  localparam int unsigned CountWidth   = 32;
  localparam int unsigned MaxChannels  = 16;

  localparam int unsigned DefaultChannels = 16;
  localparam int unsigned DefaultRatio    = 4;

  typedef logic [SampleWidth-1:0]  sample_t;
  typedef logic [ChannelWidth-1:0] channel_t;
  typedef logic [FrameWidth-1:0]   frame_t;
  typedef logic [SumWidth-1:0]     sum_t;
  typedef logic [CountWidth-1:0]   count_t;

  typedef struct packed {
    logic     valid;
    channel_t channel;
    logic     first;
    logic     emit;
    logic     last;
    sample_t  sample;
  } scan_t;

  typedef struct packed {
    logic     valid;
    channel_t channel;
    logic     last;
    count_t   count;
    sum_t     sum;
  } acc_t;

  typedef struct packed {
    logic     valid;
    channel_t channel;
    sample_t  average;
    logic     last;
    count_t   count;
  } result_t;

endpackage
`default_nettype wire

>>> sv/moa_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// moa_in_if: sample channel
// Valid/ready handshake carrying one raw converter sample per item.
// ----------------------------------------------------------------------------
interface moa_in_if;
  logic              valid;
  logic              ready;
  moa_pkg::sample_t  sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

>>> sv/moa_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// moa_out_if: average channel
// Valid/ready handshake carrying one channel average per item.
// ----------------------------------------------------------------------------
interface moa_out_if;
  logic               valid;
  logic               ready;
  moa_pkg::channel_t  channel;
  moa_pkg::sample_t   average;
  logic               block_last;
  moa_pkg::count_t    block_count;

  modport source (output valid, output channel, output average, output block_last,
                  output block_count, input ready);
  modport sink (input valid, input channel, input average, input block_last,
                input block_count, output ready);
endinterface
`default_nettype wire

>>> sv/moa_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// moa_scan: scan position tracking and input register
// Tags each accepted sample with its channel and frame role.
// ----------------------------------------------------------------------------
module moa_scan #(
  parameter int unsigned CHANNELS = moa_pkg::DefaultChannels,
  parameter int unsigned RATIO    = moa_pkg::DefaultRatio
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire moa_pkg::sample_t in_sample,
  output moa_pkg::scan_t        stage
);

  localparam moa_pkg::channel_t LastChannel = moa_pkg::ChannelWidth'(CHANNELS - 1);
  localparam moa_pkg::frame_t   LastFrame   = moa_pkg::FrameWidth'(RATIO - 1);

  moa_pkg::channel_t channel;
  moa_pkg::frame_t   frame;
  moa_pkg::channel_t channel_next;
  moa_pkg::frame_t   frame_next;
  logic              chan_wrap;
  logic              frame_wrap;

  always_comb begin
    chan_wrap    = (channel >= LastChannel);
    frame_wrap   = (frame >= LastFrame);
    channel_next = chan_wrap ? '0 : channel + 1'b1;
    frame_next   = frame;
    if (chan_wrap) begin
      frame_next = frame_wrap ? '0 : frame + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel <= '0;
      frame   <= '0;
      stage   <= '0;
    end else if (en) begin
      stage.valid   <= in_valid;
      stage.channel <= channel;
      stage.first   <= (frame == '0);
      stage.emit    <= (frame == LastFrame);
      stage.last    <= (channel == LastChannel);
      stage.sample  <= in_sample;
      if (in_valid) begin
        channel <= channel_next;
        frame   <= frame_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/moa_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// moa_accum: per-channel accumulators and block counter
// Loads or adds each sample and registers the completed channel sum.
// ----------------------------------------------------------------------------
module moa_accum (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire moa_pkg::scan_t scan,
  output moa_pkg::acc_t       stage
);

  moa_pkg::sum_t   sums [moa_pkg::MaxChannels];
  moa_pkg::count_t blocks_done;
  moa_pkg::sum_t   sum_next;
  moa_pkg::count_t count_next;

  always_comb begin
    sum_next   = scan.first ? moa_pkg::SumWidth'(scan.sample)
                            : sums[scan.channel] + moa_pkg::SumWidth'(scan.sample);
    count_next = blocks_done + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en && scan.valid) begin
      sums[scan.channel] <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_done <= '0;
      stage       <= '0;
    end else if (en) begin
      stage.valid   <= scan.valid && scan.emit;
      stage.channel <= scan.channel;
      stage.last    <= scan.last;
      stage.count   <= count_next;
      stage.sum     <= sum_next;
      if (scan.valid && scan.emit && scan.last) begin
        blocks_done <= count_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/moa_divide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// moa_divide: average by reciprocal multiply and result register
// Divides the channel sum by RATIO with a rounded-up scaled reciprocal.
// ----------------------------------------------------------------------------
module moa_divide #(
  parameter int unsigned RATIO = moa_pkg::DefaultRatio
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire moa_pkg::acc_t acc,
  output moa_pkg::result_t   result
);

  // Sum below 2^18 and reciprocal error below 64 keep the quotient exact.
  localparam int unsigned Shift     = moa_pkg::SumWidth + moa_pkg::FrameWidth;
  localparam int unsigned RecipBits = Shift + 1;
  localparam int unsigned ProdBits  = moa_pkg::SumWidth + RecipBits;
  localparam logic [RecipBits-1:0] Recip =
    RecipBits'(((64'd1 << Shift) + 64'(RATIO) - 64'd1) / 64'(RATIO));

  logic [ProdBits-1:0] product;

  assign product = ProdBits'(acc.sum) * ProdBits'(Recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      result <= '0;
    end else if (en) begin
      result.valid   <= acc.valid;
      result.channel <= acc.channel;
      result.average <= product[Shift +: moa_pkg::SampleWidth];
      result.last    <= acc.last;
      result.count   <= acc.count;
    end
  end

endmodule
`default_nettype wire

>>> sv/multichannel_oversample_averager.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_oversample_averager: scanning converter oversampling averager
// Averages RATIO scans of CHANNELS samples and reports one result per channel.
// ----------------------------------------------------------------------------
// Samples arrive in scan order, channel 0 to CHANNELS-1, repeated RATIO times
// per block. The first frame of a block loads each channel's accumulator and
// later frames add to it; during the last frame each sample yields one item
// with its channel, the truncated average, a flag on the last channel and the
// count of blocks up to and including this one. One sample is taken every
// cycle; an item passes from its closing sample through the input, accumulate
// and reciprocal-multiply registers, and the whole pipe holds while the output
// is stalled.
module multichannel_oversample_averager #(
  parameter int unsigned CHANNELS = moa_pkg::DefaultChannels,
  parameter int unsigned RATIO    = moa_pkg::DefaultRatio
) (
  input  wire logic  clk,
  input  wire logic  rst,
  moa_in_if.sink     samples,
  moa_out_if.source  averages
);

  logic             en;
  moa_pkg::scan_t   scan;
  moa_pkg::acc_t    acc;
  moa_pkg::result_t result;

  assign en            = !result.valid || averages.ready;
  assign samples.ready = en && !rst;

  moa_scan #(
    .CHANNELS (CHANNELS),
    .RATIO    (RATIO)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (samples.valid),
    .in_sample (samples.sample),
    .stage     (scan)
  );

  moa_accum u_accum (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .scan  (scan),
    .stage (acc)
  );

  moa_divide #(
    .RATIO (RATIO)
  ) u_divide (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .acc    (acc),
    .result (result)
  );

  assign averages.valid       = result.valid;
  assign averages.channel     = result.channel;
  assign averages.average     = result.average;
  assign averages.block_last  = result.last;
  assign averages.block_count = result.count;

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: oversampling averager scoreboard
// Streams whole blocks of scan-ordered samples into the averager. It predicts
// each channel average as the closing frame is accepted and compares every
// output item field by field, in order. Both sides idle and stall at random,
// and once the output is held off long enough to back up the sample input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned Channels = moa_pkg::DefaultChannels;
  localparam int unsigned Ratio    = moa_pkg::DefaultRatio;
  localparam int unsigned LongHold = 300;
  localparam int unsigned Drain    = 16;
  localparam int unsigned RandomBlocks = 7;
  localparam int unsigned CalmBlocks   = 3;

  typedef enum int {
    FILL_FRAMES,
    FILL_BITWALK,
    FILL_UNIFORM,
    FILL_EXTREMES,
    FILL_HIGH,
    FILL_LOW,
    FILL_STEADY
  } fill_e;

  typedef struct packed {
    moa_pkg::channel_t channel;
    moa_pkg::sample_t  average;
    logic              block_last;
    moa_pkg::count_t   block_count;
  } average_item_t;

  typedef struct {
    fill_e            fill;
    moa_pkg::sample_t per_frame [Ratio];
    bit               typed;
    moa_pkg::sample_t average;
    moa_pkg::count_t  block_count;
  } block_row_t;

  logic clk = 1'b0;
  logic rst;

  moa_in_if  sample_bus ();
  moa_out_if average_bus ();

  multichannel_oversample_averager #(
    .CHANNELS(Channels),
    .RATIO(Ratio)
  ) uut (
    .clk(clk),
    .rst(rst),
    .samples(sample_bus),
    .averages(average_bus)
  );

  always #10 clk = ~clk;

  // predictor state
  moa_pkg::channel_t scan_channel;
  moa_pkg::frame_t   scan_frame;
  moa_pkg::sum_t     channel_acc [moa_pkg::MaxChannels];
  moa_pkg::count_t   blocks_closed;

  average_item_t    pending_averages [$];
  block_row_t       directed_rows [6];
  moa_pkg::sample_t steady_level [moa_pkg::MaxChannels];

  int  mismatches;
  int  samples_sent;
  int  averages_seen;
  int  blocks_sent;
  bit  sender_gaps;
  bit  sink_stalls;
  bit  calm;
  bit  hold_pending;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic bit predict_average(input moa_pkg::sample_t s, output average_item_t r);
    bit fired;
    fired = 1'b0;
    r = '0;
    if (scan_frame == 0) begin
      channel_acc[scan_channel] = moa_pkg::sum_t'(s);
    end else begin
      channel_acc[scan_channel] = channel_acc[scan_channel] + moa_pkg::sum_t'(s);
    end
    if (scan_frame == moa_pkg::frame_t'(Ratio - 1)) begin
      r.channel     = scan_channel;
      r.average     = moa_pkg::sample_t'(channel_acc[scan_channel] / Ratio);
      r.block_last  = (scan_channel == moa_pkg::channel_t'(Channels - 1));
      r.block_count = blocks_closed + 32'd1;
      fired = 1'b1;
      if (r.block_last) begin
        blocks_closed = r.block_count;
      end
    end
    if (scan_channel >= moa_pkg::channel_t'(Channels - 1)) begin
      scan_channel = '0;
      scan_frame = (scan_frame >= moa_pkg::frame_t'(Ratio - 1)) ? '0 : scan_frame + 1'b1;
    end else begin
      scan_channel = scan_channel + 1'b1;
    end
    return fired;
  endfunction

  function automatic moa_pkg::sample_t block_sample(input block_row_t row, input int ch,
                                                    input int fr);
    moa_pkg::sample_t s;
    case (row.fill)
      FILL_FRAMES:   s = row.per_frame[fr];
      FILL_BITWALK:  s = moa_pkg::sample_t'(1 << ((ch + fr) % moa_pkg::SampleWidth));
      FILL_UNIFORM:  s = moa_pkg::sample_t'($urandom_range(0, 4095));
      FILL_EXTREMES: s = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      FILL_HIGH:     s = moa_pkg::sample_t'(4095 - $urandom_range(0, 63));
      FILL_LOW:      s = moa_pkg::sample_t'($urandom_range(0, 15));
      default:       s = steady_level[ch] ^ moa_pkg::sample_t'($urandom_range(0, 7));
    endcase
    return s;
  endfunction

  task automatic send_sample(input moa_pkg::sample_t s, input block_row_t row);
    average_item_t want;
    sample_bus.valid  <= 1'b1;
    sample_bus.sample <= s;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    samples_sent++;
    if (predict_average(s, want)) begin
      if (row.typed) begin
        want.average     = row.average;
        want.block_count = row.block_count;
      end
      pending_averages.push_back(want);
    end
    if (sender_gaps && !calm && $urandom_range(0, 5) == 0) begin
      sample_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_block(input block_row_t row);
    for (int fr = 0; fr < Ratio; fr++) begin
      for (int ch = 0; ch < Channels; ch++) begin
        send_sample(block_sample(row, ch, fr), row);
      end
    end
    blocks_sent++;
  endtask

  initial begin : average_sink
    average_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        average_bus.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        average_bus.ready <= 1'b1;
      end else if (sink_stalls && !calm && $urandom_range(0, 5) == 0) begin
        average_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        average_bus.ready <= 1'b1;
      end else begin
        average_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : average_check
    average_item_t want;
    if (!rst && average_bus.valid && average_bus.ready) begin
      averages_seen++;
      if (pending_averages.size() == 0) begin
        report_mismatch("unexpected average item, channel", 32'(average_bus.channel), 0);
      end else begin
        want = pending_averages.pop_front();
        if (average_bus.channel !== want.channel)
          report_mismatch("channel", 32'(average_bus.channel), 32'(want.channel));
        if (average_bus.average !== want.average)
          report_mismatch("average", 32'(average_bus.average), 32'(want.average));
        if (average_bus.block_last !== want.block_last)
          report_mismatch("block_last", 32'(average_bus.block_last), 32'(want.block_last));
        if (average_bus.block_count !== want.block_count)
          report_mismatch("block_count", average_bus.block_count, want.block_count);
      end
    end
  end

  initial begin : stimulus
    block_row_t row;
    rst               = 1'b1;
    sample_bus.valid  = 1'b0;
    sample_bus.sample = '0;
    scan_channel      = '0;
    scan_frame        = '0;
    blocks_closed     = '0;
    sender_gaps       = 1'b1;
    sink_stalls       = 1'b1;
    calm              = 1'b0;
    hold_pending      = 1'b0;
    for (int i = 0; i < moa_pkg::MaxChannels; i++) channel_acc[i] = '0;

    directed_rows = '{
      '{FILL_FRAMES, '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 1'b1, 12'd4095, 32'd1},
      '{FILL_FRAMES, '{12'h000, 12'h000, 12'h000, 12'h000}, 1'b1, 12'd0, 32'd2},
      '{FILL_FRAMES, '{12'd3, 12'd3, 12'd3, 12'd2}, 1'b1, 12'd2, 32'd3},
      '{FILL_FRAMES, '{12'hFFF, 12'h000, 12'h000, 12'h000}, 1'b1, 12'd1023, 32'd4},
      '{FILL_FRAMES, '{12'h000, 12'h000, 12'h000, 12'hFFF}, 1'b1, 12'd1023, 32'd5},
      '{FILL_BITWALK, '{12'h000, 12'h000, 12'h000, 12'h000}, 1'b0, 12'd0, 32'd0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_block(directed_rows[i]);

    // back up the input behind a long output hold
    sender_gaps  = 1'b0;
    hold_pending = 1'b1;
    for (int b = 0; b < RandomBlocks; b++) begin
      for (int ch = 0; ch < moa_pkg::MaxChannels; ch++) begin
        steady_level[ch] = moa_pkg::sample_t'($urandom);
      end
      row = directed_rows[0];
      row.typed = 1'b0;
      row.fill  = fill_e'($urandom_range(FILL_UNIFORM, FILL_STEADY));
      if (b > 0) begin
        sender_gaps = $urandom_range(0, 2) != 0;
        sink_stalls = $urandom_range(0, 2) != 0;
      end
      calm = (b >= RandomBlocks - CalmBlocks);
      send_block(row);
    end
    sample_bus.valid <= 1'b0;

    while (pending_averages.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);

    $display("Covered %0d samples over %0d blocks and %0d channel averages,",
             samples_sent, blocks_sent, averages_seen);
    $display("including a %0d-cycle output hold and random gaps on both sides.", LongHold);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
sv/moa_pkg.sv
sv/moa_in_if.sv
sv/moa_out_if.sv
sv/moa_scan.sv
sv/moa_accum.sv
sv/moa_divide.sv
sv/multichannel_oversample_averager.sv
sim/testbench.sv
